// ===== rtl/core/ssu_pkg.sv =====
`default_nettype none

package ssu_pkg;

	// default neuron count and fixed field widths
	localparam int NEURONS_DEF = 1024;
	localparam int INDEX_W     = 10;
	localparam int CFG_INDEX_W = 3;
	localparam int QUEUE_DEPTH = 2;

	// fixed-point constants
	localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
	localparam logic [47:0] AMPA_ACC_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [25:0] NMDA_ACC_MAX = 26'h3FF_FFFF;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SPIKE_THRESHOLD = 3'd0,
		REG_RESET_POTENTIAL = 3'd1,
		REG_AMPA_DECAY      = 3'd2,
		REG_RISE_DECAY      = 3'd3,
		REG_NMDA_KEEP       = 3'd4,
		REG_NMDA_GAIN       = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] spike_threshold;
		logic signed [31:0] reset_potential;
		logic [15:0]        ampa_decay;
		logic [15:0]        rise_decay;
		logic [15:0]        nmda_keep;
		logic [15:0]        nmda_gain;
	} cfg_t;

	// input request
	typedef struct packed {
		logic [INDEX_W-1:0] neuron_index;
		logic signed [31:0] membrane_v;
		logic               last_neuron;
	} item_t;

	// result request
	typedef struct packed {
		logic               spiked;
		logic signed [31:0] new_v;
		logic [47:0]        ampa_sum;
		logic [25:0]        nmda_sum;
		logic               sums_valid;
	} result_t;

	// classified job handed from front to back
	typedef struct packed {
		logic [INDEX_W-1:0] neuron_index;
		logic               in_range;
		logic               spiked;
		logic signed [31:0] new_v;
		logic               last_neuron;
	} job_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DECAY,
		ST_DRIVE,
		ST_TOTAL,
		ST_COMMIT
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssu_front.sv =====
`default_nettype none

module ssu_front #(
	parameter int NEURONS = ssu_pkg::NEURONS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ssu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]                     cfg_data,
	output ssu_pkg::cfg_t                        cfg,
	// item channel
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire ssu_pkg::item_t                  item,
	// towards the queue
	input  wire logic                            clearing,
	input  wire logic                            q_full,
	output logic                                 push,
	output ssu_pkg::job_t                        push_data
);

	ssu_pkg::cfg_t cfg_q;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (ssu_pkg::cfg_reg_t'(cfg_index))
				ssu_pkg::REG_SPIKE_THRESHOLD: cfg_q.spike_threshold <= cfg_data;
				ssu_pkg::REG_RESET_POTENTIAL: cfg_q.reset_potential <= cfg_data;
				ssu_pkg::REG_AMPA_DECAY:      cfg_q.ampa_decay      <= cfg_data[15:0];
				ssu_pkg::REG_RISE_DECAY:      cfg_q.rise_decay      <= cfg_data[15:0];
				ssu_pkg::REG_NMDA_KEEP:       cfg_q.nmda_keep       <= cfg_data[15:0];
				ssu_pkg::REG_NMDA_GAIN:       cfg_q.nmda_gain       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// hold items off while the stores are cleared or the queue is full
	assign item_stall = clearing | q_full;
	assign push       = item_valid & ~item_stall;

	// classify: spike test, reset of the potential, index range
	always_comb begin
		push_data.neuron_index = item.neuron_index;
		push_data.in_range     = (32'(item.neuron_index) < 32'(NEURONS));
		push_data.spiked       = (item.membrane_v > cfg_q.spike_threshold);
		push_data.new_v        = push_data.spiked ? cfg_q.reset_potential : item.membrane_v;
		push_data.last_neuron  = item.last_neuron;
	end

endmodule

`default_nettype wire

// ===== rtl/core/ssu_queue.sv =====
`default_nettype none

module ssu_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ssu_pkg::job_t push_data,
	output logic               full,
	input  wire logic          pop,
	output ssu_pkg::job_t      head,
	output logic               empty
);

	localparam int PTR_W = $clog2(ssu_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(ssu_pkg::QUEUE_DEPTH + 1);

	ssu_pkg::job_t    entry_q [ssu_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(ssu_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ssu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ssu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ssu_back.sv =====
`default_nettype none

module ssu_back #(
	parameter int NEURONS = ssu_pkg::NEURONS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ssu_pkg::cfg_t cfg,
	// from the queue
	input  wire logic          q_empty,
	input  wire ssu_pkg::job_t q_head,
	output logic               pop,
	output logic               clearing,
	// result channel
	output logic               result_valid,
	input  wire logic          result_stall,
	output ssu_pkg::result_t   result
);

	localparam int DEPTH  = (NEURONS < (1 << ssu_pkg::INDEX_W)) ? NEURONS
	                        : (1 << ssu_pkg::INDEX_W);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// per-neuron state memories
	logic [31:0] ampa_mem [DEPTH];
	logic [31:0] rise_mem [DEPTH];
	logic [15:0] nmda_mem [DEPTH];

	ssu_pkg::back_state_t state_q;
	ssu_pkg::back_state_t state_d;

	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;
	ssu_pkg::job_t     job_q;
	logic [31:0]       a_rd_q;
	logic [31:0]       x_rd_q;
	logic [15:0]       n_rd_q;
	logic [31:0]       a_dec_q;
	logic [31:0]       x_dec_q;
	logic [31:0]       drive_q;
	logic [31:0]       nk_q;
	logic [15:0]       nmda_new_q;
	logic [47:0]       ampa_acc_q;
	logic [25:0]       nmda_acc_q;
	logic              res_valid_q;
	ssu_pkg::result_t  res_q;

	logic              slot_free;
	logic              commit_go;
	logic              mem_we;
	logic [ADDR_W-1:0] job_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [31:0]       a_inc;
	logic [31:0]       x_inc;
	logic [47:0]       a_prod;
	logic [47:0]       x_prod;
	logic [47:0]       d_prod;
	logic [16:0]       inv_n;
	logic [48:0]       t_prod;
	logic [49:0]       t_sum;
	logic [48:0]       a_sum;
	logic [26:0]       n_sum;
	logic [47:0]       ampa_next;
	logic [25:0]       nmda_next;

	assign job_addr  = job_q.neuron_index[ADDR_W-1:0];
	assign slot_free = ~res_valid_q | ~result_stall;
	assign clearing  = clearing_q;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssu_pkg::ST_IDLE:   if (!clearing_q && !q_empty) state_d = ssu_pkg::ST_READ;
			ssu_pkg::ST_READ:   state_d = ssu_pkg::ST_DECAY;
			ssu_pkg::ST_DECAY:  state_d = ssu_pkg::ST_DRIVE;
			ssu_pkg::ST_DRIVE:  state_d = ssu_pkg::ST_TOTAL;
			ssu_pkg::ST_TOTAL:  state_d = ssu_pkg::ST_COMMIT;
			ssu_pkg::ST_COMMIT: if (slot_free) state_d = ssu_pkg::ST_IDLE;
			default:            state_d = ssu_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop       = 1'b0;
		commit_go = 1'b0;
		case (state_q)
			ssu_pkg::ST_IDLE:   pop = ~clearing_q & ~q_empty;
			ssu_pkg::ST_COMMIT: commit_go = slot_free;
			default: ;
		endcase
	end

	// clearing pass over the stores after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// memory write port: clearing pass or write-back
	assign mem_we  = clearing_q | (commit_go & job_q.in_range);
	assign wr_addr = clearing_q ? clr_addr_q : job_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ampa_mem[wr_addr] <= clearing_q ? 32'd0 : a_dec_q;
			rise_mem[wr_addr] <= clearing_q ? 32'd0 : x_dec_q;
			nmda_mem[wr_addr] <= clearing_q ? 16'd0 : nmda_new_q;
		end
	end

	// memory read port, registered
	always_ff @(posedge clk) begin
		a_rd_q <= ampa_mem[job_addr];
		x_rd_q <= rise_mem[job_addr];
		n_rd_q <= nmda_mem[job_addr];
	end

	// spike increment with saturation, then decay
	always_comb begin
		a_inc  = a_rd_q;
		x_inc  = x_rd_q;
		if (job_q.spiked) begin
			a_inc = (a_rd_q > ~ssu_pkg::ONE_Q16) ? 32'hFFFF_FFFF : a_rd_q + ssu_pkg::ONE_Q16;
			x_inc = (x_rd_q > ~ssu_pkg::ONE_Q16) ? 32'hFFFF_FFFF : x_rd_q + ssu_pkg::ONE_Q16;
		end
		a_prod = a_inc * cfg.ampa_decay;
		x_prod = x_inc * cfg.rise_decay;
	end

	// nmda drive and retention
	assign d_prod = x_dec_q * cfg.nmda_gain;
	assign inv_n  = 17'h1_0000 - {1'b0, n_rd_q};
	assign t_prod = drive_q * inv_n;
	assign t_sum  = {1'b0, t_prod} + {18'd0, nk_q};

	// pooled sums with saturation
	assign a_sum     = {1'b0, ampa_acc_q} + {17'd0, a_dec_q};
	assign n_sum     = {1'b0, nmda_acc_q} + {11'd0, nmda_new_q};
	assign ampa_next = !job_q.in_range ? ampa_acc_q
	                   : (a_sum[48] ? ssu_pkg::AMPA_ACC_MAX : a_sum[47:0]);
	assign nmda_next = !job_q.in_range ? nmda_acc_q
	                   : (n_sum[26] ? ssu_pkg::NMDA_ACC_MAX : n_sum[25:0]);

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
		end
		if (state_q == ssu_pkg::ST_DECAY) begin
			a_dec_q <= a_prod[47:16];
			x_dec_q <= x_prod[47:16];
		end
		if (state_q == ssu_pkg::ST_DRIVE) begin
			drive_q <= d_prod[47:16];
			nk_q    <= n_rd_q * cfg.nmda_keep;
		end
		if (state_q == ssu_pkg::ST_TOTAL) begin
			nmda_new_q <= (|t_sum[49:32]) ? 16'hFFFF : t_sum[31:16];
		end
	end

	// pool accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ampa_acc_q <= '0;
			nmda_acc_q <= '0;
		end else if (commit_go) begin
			ampa_acc_q <= job_q.last_neuron ? '0 : ampa_next;
			nmda_acc_q <= job_q.last_neuron ? '0 : nmda_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit_go) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			res_q.spiked     <= job_q.spiked;
			res_q.new_v      <= job_q.new_v;
			res_q.ampa_sum   <= job_q.last_neuron ? ampa_next : '0;
			res_q.nmda_sum   <= job_q.last_neuron ? nmda_next : '0;
			res_q.sums_valid <= job_q.last_neuron;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/spiking_synapse_update_core.sv =====
// Synaptic gating update for an excitatory pool, one neuron per request.
// Item channel (item_valid / item_stall / item) carries the neuron index, its
// membrane potential and the last-of-step mark; a request is taken when
// item_valid is high and item_stall low. Result channel (result_valid /
// result_stall / result) returns one request per item, in order: spike flag,
// new potential and, on the last neuron of a step, the pooled AMPA and NMDA
// sums, which are then cleared. Configuration is to be written through cfg_valid /
// cfg_ready / cfg_index / cfg_data only while the block is idle; the block itself
// does not enforce this, and cfg_ready is always high.
// The back-end sequencer steps through pop, memory read, decay multiply, drive
// multiply, NMDA total and commit, and takes the next item only after that
// commit, which waits while the output register is held; a two-entry queue
// sits between front and back.
// After reset the state memories are zeroed by a clearing pass over
// min(NEURONS, 1024) entries, during which item_stall is high.
// When the receiver stalls, the result is held in the output register, and
// further items fill the queue until item_stall rises.
`default_nettype none

module spiking_synapse_update_core #(
	parameter int NEURONS = ssu_pkg::NEURONS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ssu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]                     cfg_data,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire ssu_pkg::item_t                  item,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output ssu_pkg::result_t                     result
);

	ssu_pkg::cfg_t cfg;
	ssu_pkg::job_t push_data;
	ssu_pkg::job_t q_head;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;
	logic          clearing;

	// front: configuration and classification
	ssu_front #(
		.NEURONS (NEURONS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.clearing   (clearing),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	// decoupling queue
	ssu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// back: state update and pooling
	ssu_back #(
		.NEURONS (NEURONS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.pop          (pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
